// ===== hdl/asrt_pkg.sv =====
package asrt_pkg;

    localparam int PAGE_SHIFT = 12;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERLAP   = 3'd1,
        ST_NO_SPACE  = 3'd2,
        ST_FULL      = 3'd3,
        ST_NO_REGION = 3'd4,
        ST_WRITE_PROT = 3'd5
    } status_t;

    localparam logic OP_MAP   = 1'b0;
    localparam logic OP_FAULT = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [47:0] address;
        logic [46:0] length;
        logic        fixed_request;
        logic [2:0]  prot;
        logic [31:0] map_flags;
        logic [15:0] file_handle;
        logic [47:0] file_offset;
        logic        write_access;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] mapped_base;
        logic [47:0] found_base;
        logic [46:0] found_length;
        logic [2:0]  found_prot;
    } rsp_t;

    // One stored region.
    typedef struct packed {
        logic [47:0] base;
        logic [46:0] length;
        logic [2:0]  prot;
        logic [31:0] flags;
        logic [15:0] file;
        logic [47:0] offset;
    } region_t;

    // Work token passed from cell to cell during a scan.
    typedef struct packed {
        logic        active;
        logic        op;
        logic        fixed;
        logic [49:0] lo;
        logic [49:0] hi_size;
        logic [47:0] addr;
        logic        hit;
        region_t     hit_reg;
    } tok_t;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_INSERT, S_OUT
    } state_t;

endpackage

// ===== hdl/asrt_cell.sv =====
module asrt_cell
    import asrt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     valid_in,      // entry index below count
    input  logic     ins_go,        // insert pulse
    input  logic [47:0] ins_base,
    input  region_t  ins_reg,
    input  region_t  prev_reg,      // left neighbor's entry
    input  logic     prev_gt,       // left neighbor base > insert base
    input  logic     prev_valid,
    input  logic     first,
    input  tok_t     tok_in,
    output tok_t     tok_out,
    output region_t  reg_out,
    output logic     gt_out
);

    region_t reg_reg;
    tok_t    tok_reg;
    logic [49:0] ext_lo;
    logic [49:0] ext_top;
    logic [47:0] len1;
    logic [49:0] cur_hi;
    tok_t    tok_next;

    assign reg_out = reg_reg;
    assign gt_out  = valid_in && (reg_reg.base > ins_base);

    // Extent of the held region.
    always_comb begin
        len1    = (reg_reg.length == '0) ? 48'd1 : {1'b0, reg_reg.length};
        ext_lo  = {2'b00, reg_reg.base[47:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
        ext_top = ({2'b00, reg_reg.base} + {2'b00, len1} + 50'hFFF) & ~50'hFFF;
    end

    // Update the scan token with this cell's region.
    always_comb begin
        tok_next = tok_in;
        cur_hi   = tok_in.fixed ? tok_in.hi_size : tok_in.lo + tok_in.hi_size;
        if (tok_in.active && valid_in) begin
            if (tok_in.op == OP_MAP) begin
                if (tok_in.lo < ext_top && ext_lo < cur_hi) begin
                    if (tok_in.fixed) begin
                        tok_next.hit = 1'b1;
                    end else begin
                        tok_next.lo = ext_top;
                    end
                end
            end else if (!tok_in.hit && {2'b00, tok_in.addr} >= {2'b00, reg_reg.base}
                         && {2'b00, tok_in.addr} < ext_top) begin
                tok_next.hit     = 1'b1;
                tok_next.hit_reg = reg_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.active <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end
    assign tok_out = tok_reg;

    // Sorted insert: shift right where the left neighbor is larger.
    always_ff @(posedge aclk) begin
        if (ins_go) begin
            if (!first && prev_valid && prev_gt) begin
                reg_reg <= prev_reg;
            end else if (gt_out || (!valid_in && (first || !prev_valid || !prev_gt)
                         && (first || prev_valid))) begin
                reg_reg <= ins_reg;
            end
        end
    end

endmodule

// ===== hdl/address_space_region_table_top.sv =====
// Region table of MAX_REGIONS entries held in a chain of cells sorted by base.
// Each request injects a token that walks the chain one cell per cycle; once
// the token has passed the last cell, the decide state settles the outcome,
// the insert state stores a map that succeeds (all cells shift at once), and
// the result is then offered in the output state. One item is in work at a
// time, so a held result delays the next input until it is accepted. The
// limit register is written with cfg_we and should change only while no
// item is in work.
module address_space_region_table_top
    import asrt_pkg::*;
#(
    parameter int MAX_REGIONS = 32
)(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [48:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  req_t        s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output rsp_t        m_data
);

    localparam int CW = $clog2(MAX_REGIONS + 1);

    state_t st_reg, st_next;
    logic [48:0] limit_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] cnt_reg;
    req_t req_reg;
    rsp_t rsp_reg;
    rsp_t rsp_next;
    logic [49:0] base_reg;
    logic [49:0] base_next;
    logic ok_reg;
    logic ok_next;
    tok_t inj;
    tok_t toks [MAX_REGIONS+1];
    region_t regs [MAX_REGIONS];
    logic gts [MAX_REGIONS];
    logic vals [MAX_REGIONS];
    logic ins_go;
    region_t ins_reg;
    tok_t res;
    logic [49:0] eff_lim;

    assign res = toks[MAX_REGIONS];
    assign s_ready = (st_reg == S_IDLE);
    assign m_valid = (st_reg == S_OUT);
    assign m_data = rsp_reg;
    assign ins_go = (st_reg == S_INSERT);

    always_comb begin
        eff_lim = (limit_reg > 49'h1_0000_0000_0000) ? 50'h1_0000_0000_0000
                                                    : {1'b0, limit_reg};
        ins_reg = '{base: base_reg[47:0], length: req_reg.length, prot: req_reg.prot,
                    flags: req_reg.map_flags, file: req_reg.file_handle,
                    offset: req_reg.file_offset};
        inj = '0;
        inj.active = (st_reg == S_IDLE) && s_valid;
        inj.op = s_data.opcode;
        inj.fixed = s_data.fixed_request;
        inj.addr = s_data.address;
        if (s_data.fixed_request) begin
            inj.lo = {2'b00, s_data.address[47:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
            inj.hi_size = ({2'b00, s_data.address}
                + {2'b00, ((s_data.length == '0 ? 48'd1 : {1'b0, s_data.length})
                + 48'hFFF) & ~48'hFFF} + 50'hFFF) & ~50'hFFF;
        end else begin
            inj.lo = (s_data.address < 48'h1000) ? 50'h1000
                   : {2'b00, s_data.address[47:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
            inj.hi_size = {2'b00, ((s_data.length == '0 ? 48'd1 : {1'b0, s_data.length})
                + 48'hFFF) & ~48'hFFF};
        end
    end

    assign toks[0] = inj;

    // The chain of cells.
    for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
        assign vals[g] = (CW'(g) < count_reg);
        asrt_cell u_cell (
            .aclk(aclk), .aresetn(aresetn),
            .valid_in(vals[g]), .ins_go(ins_go && ok_reg),
            .ins_base(base_reg[47:0]), .ins_reg(ins_reg),
            .prev_reg(g == 0 ? regs[0] : regs[(g == 0) ? 0 : g-1]),
            .prev_gt(g == 0 ? 1'b0 : gts[(g == 0) ? 0 : g-1]),
            .prev_valid(g == 0 ? 1'b0 : vals[(g == 0) ? 0 : g-1]),
            .first(g == 0),
            .tok_in(toks[g]), .tok_out(toks[g+1]),
            .reg_out(regs[g]), .gt_out(gts[g])
        );
    end

    // Sequencer. The token enters the last cell on the edge that leaves the scan.
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE:   if (s_valid) st_next = S_SCAN;
            S_SCAN:   if (cnt_reg == CW'(MAX_REGIONS - 2)) st_next = S_DECIDE;
            S_DECIDE: st_next = S_INSERT;
            S_INSERT: st_next = S_OUT;
            S_OUT:    if (m_ready) st_next = S_IDLE;
            default:  st_next = S_IDLE;
        endcase
    end

    // Outcome of the finished scan.
    always_comb begin
        base_next = req_reg.fixed_request ? {2'b00, req_reg.address} : res.lo;
        rsp_next = '0;
        ok_next = 1'b0;
        if (req_reg.opcode == OP_MAP) begin
            if (count_reg == CW'(MAX_REGIONS)) begin
                rsp_next.status = ST_FULL;
            end else if (req_reg.fixed_request && res.hit) begin
                rsp_next.status = ST_OVERLAP;
            end else if ((base_next == '0) || (base_next >= eff_lim)) begin
                rsp_next.status = ST_NO_SPACE;
            end else begin
                ok_next = 1'b1;
                rsp_next.status = ST_OK;
                rsp_next.mapped_base = base_next[47:0];
                rsp_next.found_base = base_next[47:0];
                rsp_next.found_length = req_reg.length;
                rsp_next.found_prot = req_reg.prot;
            end
        end else if (res.hit) begin
            rsp_next.status = (req_reg.write_access && !res.hit_reg.prot[1])
                              ? ST_WRITE_PROT : ST_OK;
            rsp_next.found_base = res.hit_reg.base;
            rsp_next.found_length = res.hit_reg.length;
            rsp_next.found_prot = res.hit_reg.prot;
        end else begin
            rsp_next.status = ST_NO_REGION;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= S_IDLE;
            limit_reg <= 49'h0_8000_0000_0000;
            count_reg <= '0;
            cnt_reg   <= '0;
            ok_reg    <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (cfg_we) limit_reg <= cfg_wdata;
            if (st_reg == S_IDLE) cnt_reg <= '0;
            else if (st_reg == S_SCAN) cnt_reg <= cnt_reg + 1'b1;
            if (st_reg == S_DECIDE) ok_reg <= ok_next;
            if (ins_go && ok_reg) count_reg <= count_reg + 1'b1;
        end
    end

    // Result and payload registers.
    always_ff @(posedge aclk) begin
        if (st_reg == S_IDLE && s_valid) req_reg <= s_data;
        if (st_reg == S_DECIDE) begin
            base_reg <= base_next;
            rsp_reg  <= rsp_next;
        end
    end

endmodule

// ===== bench/address_space_region_table_top_tb.sv =====
module address_space_region_table_top_tb
    import asrt_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NREG = 32;
    localparam longint unsigned PG = 64'd4096;
    localparam longint unsigned ADDR_TOP = 64'h1_0000_0000_0000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [48:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    req_t        s_data;
    logic        m_valid;
    logic        m_ready;
    rsp_t        m_data;

    address_space_region_table_top #(.MAX_REGIONS(NREG)) dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the region table.
    longint unsigned tbl_base[NREG];
    longint unsigned tbl_len[NREG];
    logic [2:0]      tbl_prot[NREG];
    int              tbl_count;
    longint unsigned space_limit;

    rsp_t rsp_pending[$];
    int   fail_count;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_cycles;

    function automatic longint unsigned pg_down(longint unsigned v);
        return v - (v % PG);
    endfunction

    function automatic longint unsigned pg_up(longint unsigned v);
        return pg_down(v + PG - 1);
    endfunction

    function automatic longint unsigned region_top(int i);
        longint unsigned n;
        n = (tbl_len[i] != 0) ? tbl_len[i] : 1;
        return pg_up(tbl_base[i] + n);
    endfunction

    // Applies one request to the shadow table and returns the response it gives.
    function automatic rsp_t table_apply(req_t r);
        rsp_t            o;
        longint unsigned addr, len, size, lim, cur, base, lo, hi;
        int              pos;
        bit              hit;
        o = '0;
        addr = r.address;
        len = r.length;
        lim = (space_limit > ADDR_TOP) ? ADDR_TOP : space_limit;
        if (r.opcode == OP_MAP) begin
            size = pg_up((len != 0) ? len : 1);
            if (tbl_count >= NREG) begin
                o.status = ST_FULL;
                return o;
            end
            if (r.fixed_request) begin
                lo = pg_down(addr);
                hi = pg_up(addr + size);
                hit = 0;
                for (int i = 0; i < tbl_count; i++)
                    if (lo < region_top(i) && pg_down(tbl_base[i]) < hi) hit = 1;
                if (hit) begin
                    o.status = ST_OVERLAP;
                    return o;
                end
                base = addr;
            end else begin
                cur = pg_down((addr < PG) ? PG : addr);
                for (int i = 0; i < tbl_count; i++)
                    if (cur < region_top(i) && pg_down(tbl_base[i]) < cur + size)
                        cur = region_top(i);
                base = cur;
            end
            if (base == 0 || base >= lim) begin
                o.status = ST_NO_SPACE;
                return o;
            end
            pos = tbl_count;
            while (pos > 0 && tbl_base[pos-1] > base) begin
                tbl_base[pos] = tbl_base[pos-1];
                tbl_len[pos]  = tbl_len[pos-1];
                tbl_prot[pos] = tbl_prot[pos-1];
                pos--;
            end
            tbl_base[pos] = base;
            tbl_len[pos]  = len;
            tbl_prot[pos] = r.prot;
            tbl_count++;
            o.status       = ST_OK;
            o.mapped_base  = base[47:0];
            o.found_base   = base[47:0];
            o.found_length = len[46:0];
            o.found_prot   = r.prot;
            return o;
        end
        for (int i = 0; i < tbl_count; i++) begin
            if (addr >= tbl_base[i] && addr < region_top(i)) begin
                o.status = (r.write_access && !tbl_prot[i][1]) ? ST_WRITE_PROT : ST_OK;
                o.found_base   = tbl_base[i][47:0];
                o.found_length = tbl_len[i][46:0];
                o.found_prot   = tbl_prot[i];
                return o;
            end
        end
        o.status = ST_NO_REGION;
        return o;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Sends one request, idling beforehand at the current rate. Valid stays
    // high after the transfer until the next request or an idle cycle.
    task automatic send_req(req_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        rsp_pending.push_back(table_apply(r));
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Receiver: random stalls, plus an optional long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compares each response transfer with the oldest expectation.
    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (rsp_pending.size() == 0) begin
                report_mismatch("unexpected response", m_data, 0);
            end else begin
                want = rsp_pending.pop_front();
                if (m_data.status != want.status)
                    report_mismatch("status", m_data.status, want.status);
                if (m_data.mapped_base != want.mapped_base)
                    report_mismatch("mapped_base", m_data.mapped_base, want.mapped_base);
                if (m_data.found_base != want.found_base)
                    report_mismatch("found_base", m_data.found_base, want.found_base);
                if (m_data.found_length != want.found_length)
                    report_mismatch("found_length", m_data.found_length, want.found_length);
                if (m_data.found_prot != want.found_prot)
                    report_mismatch("found_prot", m_data.found_prot, want.found_prot);
            end
        end
    end

    function automatic req_t make_req(logic op, longint unsigned addr, longint unsigned len,
                                      logic fixed, logic [2:0] prot, logic wr);
        req_t r;
        r.opcode        = op;
        r.address       = addr[47:0];
        r.length        = len[46:0];
        r.fixed_request = fixed;
        r.prot          = prot;
        r.map_flags     = $urandom;
        r.file_handle   = 16'($urandom);
        r.file_offset   = 48'({$urandom, $urandom});
        r.write_access  = wr;
        return r;
    endfunction

    task automatic drain();
        s_valid <= 1'b0;
        while (rsp_pending.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    // The limit register changes only while the block is idle.
    task automatic set_limit(longint unsigned v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v[48:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        space_limit = v & 64'h1_FFFF_FFFF_FFFF;
    endtask

    // Random length, mostly small, rarely huge.
    function automatic longint unsigned rand_len();
        case ($urandom_range(9))
            0: return 0;
            1: return {$urandom, $urandom} & 64'h7FFF_FFFF_FFFF;
            2: return $urandom_range(1, 3) * PG;
            default: return $urandom_range(1, 5 * 4096);
        endcase
    endfunction

    // Addresses clustered low in the space so regions collide often.
    function automatic longint unsigned rand_addr();
        case ($urandom_range(9))
            0: return {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF;
            1: return $urandom_range(0, 4095);
            default: return 64'h1000_0000 + $urandom_range(0, 400000);
        endcase
    endfunction

    // A fault address near a known region, or random.
    function automatic longint unsigned fault_addr();
        int i;
        if (tbl_count == 0 || $urandom_range(4) == 0) return rand_addr();
        i = $urandom_range(0, tbl_count - 1);
        return tbl_base[i] + $urandom_range(0, 9000) - 100;
    endfunction

    task automatic test_directed();
        send_req(make_req(OP_FAULT, 0, 0, 0, 0, 0));
        send_req(make_req(OP_MAP, 0, 0, 0, 3'b111, 0));
        send_req(make_req(OP_MAP, 0, 0, 1, 3'b001, 0));
        send_req(make_req(OP_MAP, 64'h5000, 64'h1, 1, 3'b001, 0));
        send_req(make_req(OP_MAP, 64'h5800, 64'h10, 1, 3'b010, 0));
        send_req(make_req(OP_MAP, 64'h3000, 64'h3000, 1, 3'b011, 0));
        send_req(make_req(OP_MAP, 64'h2000, 64'h1000, 0, 3'b100, 0));
        send_req(make_req(OP_MAP, 64'h7FFF_FFFF_F000, 64'h1000, 1, 3'b011, 0));
        send_req(make_req(OP_MAP, 64'h8000_0000_0000, 64'h1000, 1, 3'b011, 0));
        send_req(make_req(OP_MAP, 64'hFFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF, 0, 3'b011, 0));
        send_req(make_req(OP_MAP, 64'h10_0000, 64'h7FFF_FFFF_FFFF, 0, 3'b110, 0));
        send_req(make_req(OP_FAULT, 64'h5000, 0, 0, 0, 1));
        send_req(make_req(OP_FAULT, 64'h5FFF, 0, 0, 0, 0));
        send_req(make_req(OP_FAULT, 64'h6000, 0, 0, 0, 1));
        send_req(make_req(OP_FAULT, 64'h3800, 0, 0, 0, 1));
        send_req(make_req(OP_FAULT, 64'hFFFF_FFFF_FFFF, 0, 0, 0, 1));
        send_req(make_req(OP_FAULT, 64'h2000, 0, 0, 0, 0));
    endtask

    // Fills the table to capacity, then probes it. The number of tries is
    // bounded, since earlier huge regions may leave no room above the hint.
    task automatic test_table_full();
        for (int k = 0; k < 4 * NREG && tbl_count < NREG; k++)
            send_req(make_req(OP_MAP, 64'h4000_0000, $urandom_range(1, 8192), 1'b0,
                              3'($urandom), 1'b0));
        send_req(make_req(OP_MAP, 64'h9000_0000, 64'h1000, 1, 3'b011, 0));
        send_req(make_req(OP_MAP, 0, 0, 0, 3'b011, 0));
        repeat (6) send_req(make_req(OP_FAULT, fault_addr(), 0, 0, 0, 1'($urandom)));
    endtask

    // Mixed maps and fault checks; once the table is full only fault checks
    // are sent.
    task automatic test_random(int n);
        req_t r;
        for (int k = 0; k < n; k++) begin
            if (tbl_count < NREG && $urandom_range(99) < 45)
                r = make_req(OP_MAP, rand_addr(), rand_len(), 1'($urandom), 3'($urandom),
                             1'($urandom));
            else
                r = make_req(OP_FAULT, fault_addr(), rand_len(), 1'($urandom), 3'($urandom),
                             1'($urandom));
            send_req(r);
        end
    endtask

    // The receiver holds off while the sender keeps offering.
    task automatic test_backpressure();
        hold_cycles = 400;
        test_random(10);
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data = '0;
        tbl_count = 0;
        space_limit = 64'h8000_0000_0000;
        fail_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(100);
        send_idle_pct = 48;
        test_random(100);
        send_idle_pct = 0;
        recv_stall_pct = 48;
        test_backpressure();
        test_random(90);
        send_idle_pct = 32;
        recv_stall_pct = 32;
        test_table_full();

        // The table may be full now; the limit register then affects nothing until
        // it is checked against fresh maps, so vary it with fault checks in between.
        set_limit(64'h1000);
        send_req(make_req(OP_MAP, 64'h1000, 0, 1, 3'b011, 0));
        set_limit(64'h1_FFFF_FFFF_FFFF);
        test_random(80);
        set_limit(64'h1_0000_0000_0000);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(80);
        set_limit(64'h4000_2000);
        test_random(60);

        drain();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end
endmodule
